@@ rtl/weighted_degree_rbf_kernel_defines.svh @@
`ifndef WEIGHTED_DEGREE_RBF_KERNEL_DEFINES_SVH
`define WEIGHTED_DEGREE_RBF_KERNEL_DEFINES_SVH

// same-cycle implication
`define WDRK_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wdrk check failed");

// next-cycle implication
`define WDRK_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wdrk check failed");

`endif

@@ rtl/wdrk_pkg.sv @@
package wdrk_pkg;

   localparam int MAX_GROUP      = 16;
   localparam int EXP_TABLE_SIZE = 256;
   localparam int EXP_IDX_W      = $clog2(EXP_TABLE_SIZE);
   localparam int EXP_W          = 17;
   localparam int FRAC_W         = 16;
   localparam int DATA_W         = 16;
   localparam int DIFF_W         = 17;
   localparam int SQ_W           = 34;
   localparam int SUM_W          = 48;
   localparam int TOTAL_W        = 40;
   localparam int OUT_W          = 32;
   localparam int INV_W          = 24;
   localparam int WS_W           = 17;
   localparam int DEG_W          = 4;
   localparam int GS_W           = 5;
   localparam int CSR_W          = 24;
   localparam int CSR_IDX_W      = 2;
   localparam int WEIGHT_W       = WS_W + EXP_W;
   localparam int CONTRIB_W      = WEIGHT_W + DEG_W - FRAC_W;
   localparam int PROD_W         = SUM_W + INV_W;
   localparam int PART_W         = INV_W + INV_W;
   localparam int XPOINT         = 36;
   localparam real EXP_STEP      = 16.0 / EXP_TABLE_SIZE;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INV_WIDTH,
      CSR_DEGREE,
      CSR_GROUP_SIZE,
      CSR_WEIGHT_SCALE
   } csr_index_type;

   typedef struct packed {
      logic group_end;
      logic clear;
      logic shift;
   } cell_ctl_type;

   typedef logic [EXP_W-1:0] exp_tab_type [0:EXP_TABLE_SIZE];

   function automatic exp_tab_type build_exp_tab();
      exp_tab_type t;
      real v;
      for (int k = 0; k <= EXP_TABLE_SIZE; k++) begin
         v = 65536.0 * $exp(-EXP_STEP * real'(k));
         t[k] = EXP_W'($rtoi(v + 0.5));
      end
      return t;
   endfunction

   localparam exp_tab_type EXP_TAB = build_exp_tab();

endpackage

@@ rtl/wdrk_cell.sv @@
module wdrk_cell
   import wdrk_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cell_ctl_type     ctl,
   input  logic [SUM_W-1:0] group_sum,
   input  logic [SUM_W-1:0] prev_sum,
   input  logic             prev_act,
   input  logic [SUM_W-1:0] eval_in_sum,
   input  logic             eval_in_act,
   output logic [SUM_W-1:0] sum,
   output logic             act,
   output logic [SUM_W-1:0] eval_sum,
   output logic             eval_act
);

   logic [SUM_W-1:0] sum_ff, sum_in, eval_sum_ff;
   logic             act_ff, eval_act_ff;

   assign sum_in = prev_sum + group_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff      <= 1'b0;
         eval_act_ff <= 1'b0;
      end else if (ctl.group_end) begin
         act_ff      <= prev_act & ~ctl.clear;
         eval_act_ff <= prev_act;
      end else begin
         if (ctl.clear) act_ff <= 1'b0;
         if (ctl.shift) eval_act_ff <= eval_in_act;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.group_end) begin
         sum_ff      <= sum_in;
         eval_sum_ff <= sum_in;
      end else if (ctl.shift) begin
         eval_sum_ff <= eval_in_sum;
      end
   end

   assign sum      = sum_ff;
   assign act      = act_ff;
   assign eval_sum = eval_sum_ff;
   assign eval_act = eval_act_ff;

endmodule

@@ rtl/wdrk_exp.sv @@
module wdrk_exp
   import wdrk_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [SUM_W-1:0]     in_sum,
   input  logic [DEG_W-1:0]     in_factor,
   input  logic [INV_W-1:0]     inv_width,
   input  logic [WS_W-1:0]      weight_scale,
   output logic                 out_valid,
   output logic [CONTRIB_W-1:0] out_contrib,
   output logic                 busy
);

   logic [6:0] v_ff;
   logic [DEG_W-1:0] f1_ff, f2_ff, f3_ff, f4_ff, f5_ff, f6_ff;
   logic [PART_W-1:0] pl_ff, ph_ff;
   logic [PROD_W-1:0] p_in;
   logic [EXP_IDX_W-1:0] idx_ff;
   logic [FRAC_W-1:0] frac_ff, frac3_ff;
   logic ovf_ff;
   logic [EXP_IDX_W:0] idx_p1;
   logic [EXP_W-1:0] hi3_ff, dif3_ff, hi4_ff, ex_ff;
   logic [EXP_W+FRAC_W-1:0] m4_ff;
   logic [WEIGHT_W-1:0] w_ff;
   logic [WEIGHT_W+DEG_W-1:0] wf;
   logic [CONTRIB_W-1:0] c_ff;

   assign p_in   = {{INV_W{1'b0}}, pl_ff} + {ph_ff, {INV_W{1'b0}}};
   assign idx_p1 = {1'b0, idx_ff} + 1'b1;
   assign wf     = w_ff * f6_ff;

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else       v_ff <= {v_ff[5:0], in_valid};
   end

   always_ff @(posedge clock) begin
      pl_ff    <= in_sum[INV_W-1:0] * inv_width;
      ph_ff    <= in_sum[SUM_W-1:INV_W] * inv_width;
      f1_ff    <= in_factor;
      ovf_ff   <= |p_in[PROD_W-1:XPOINT];
      idx_ff   <= p_in[XPOINT-1 -: EXP_IDX_W];
      frac_ff  <= p_in[XPOINT-1-EXP_IDX_W -: FRAC_W];
      f2_ff    <= f1_ff;
      hi3_ff   <= ovf_ff ? '0 : EXP_TAB[idx_ff];
      dif3_ff  <= ovf_ff ? '0 : EXP_TAB[idx_ff] - EXP_TAB[idx_p1];
      frac3_ff <= frac_ff;
      f3_ff    <= f2_ff;
      m4_ff    <= dif3_ff * frac3_ff;
      hi4_ff   <= hi3_ff;
      f4_ff    <= f3_ff;
      ex_ff    <= hi4_ff - m4_ff[EXP_W+FRAC_W-1:FRAC_W];
      f5_ff    <= f4_ff;
      w_ff     <= weight_scale * ex_ff;
      f6_ff    <= f5_ff;
      c_ff     <= wf[WEIGHT_W+DEG_W-1:FRAC_W];
   end

   assign out_valid   = v_ff[6];
   assign out_contrib = c_ff;
   assign busy        = |v_ff;

endmodule

@@ rtl/weighted_degree_rbf_kernel.sv @@
// Weighted-degree RBF kernel over two streamed Q8.8 vectors.
// Input beats (req_) carry one element pair each; req_last marks the final
// pair. One result beat (rsp_) follows each last beat: the Q16.16 kernel
// value saturated at 2^32-1, and a flag set when the vector ended inside a
// group. Registers are written through csr_; the user must write them only
// while the block is idle, which the block itself does not enforce. Pairs
// that do not close a group are taken one per cycle while no evaluation is
// under way. A pair that closes a group holds req_stall high while the start
// cells are unloaded one per cycle into the shared exponent pipeline and
// until the seven-stage exponent unit has drained. A last beat inside a
// group answers once it has passed the difference, square and accumulate
// stages and the result register; one closing a group, after its evaluation.
// A result waiting on rsp_stall holds; further pairs are still taken, but a
// new last beat is stalled until the waiting result leaves.
// Reset restores register defaults, clears all vector state and drops
// rsp_valid.
module weighted_degree_rbf_kernel
   import wdrk_pkg::*;
#(
   parameter int MAX_DEGREE = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [DATA_W-1:0] req_a_value,
   input  logic signed [DATA_W-1:0] req_b_value,
   input  logic                     req_last,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [OUT_W-1:0]         rsp_kernel_value,
   output logic                     rsp_length_error,
   input  logic                     csr_write,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_W-1:0]         csr_wdata
);

   logic [INV_W-1:0] inv_width_ff;
   logic [DEG_W-1:0] degree_ff, deg_eff;
   logic [GS_W-1:0]  group_size_ff, gs_eff, pos_ff;
   logic [WS_W-1:0]  weight_scale_ff;

   logic accept, ge;
   logic [GS_W:0] pos_p1;
   logic signed [DIFF_W-1:0] diff;

   logic s1_valid_ff, s1_ge_ff, s1_last_ff;
   logic [DIFF_W-1:0] s1_abs_ff;
   logic s2_valid_ff, s2_ge_ff, s2_last_ff;
   logic [SQ_W-1:0] s2_sq_ff;
   logic s3_valid_ff, s3_ge_ff, s3_last_ff;
   logic [SUM_W-1:0] s3_g_ff, gsum_ff, g_in;

   logic busy_ff, evaluating_ff, issuing_ff, eval_last_ff, last_inflight_ff;
   logic [DEG_W-1:0] cnt_ff;
   logic done, emit_inside, emit;
   logic [TOTAL_W-1:0] total_ff;
   logic [TOTAL_W:0] total_sum;
   logic rsp_valid_ff, rsp_err_ff;
   logic [OUT_W-1:0] rsp_value_ff;

   cell_ctl_type ctl;
   logic [SUM_W-1:0] c_sum [MAX_DEGREE];
   logic             c_act [MAX_DEGREE];
   logic [SUM_W-1:0] e_sum [MAX_DEGREE];
   logic             e_act [MAX_DEGREE];

   logic exp_valid, exp_busy;
   logic [CONTRIB_W-1:0] exp_contrib;

   always_comb begin
      if (degree_ff == '0)              deg_eff = DEG_W'(1);
      else if (degree_ff > MAX_DEGREE)  deg_eff = DEG_W'(MAX_DEGREE);
      else                              deg_eff = degree_ff;
      if (group_size_ff == '0)          gs_eff = GS_W'(1);
      else if (group_size_ff > MAX_GROUP) gs_eff = GS_W'(MAX_GROUP);
      else                              gs_eff = group_size_ff;
   end

   assign pos_p1    = {1'b0, pos_ff} + 1'b1;
   assign ge        = pos_p1 >= {1'b0, gs_eff};
   assign req_stall = busy_ff | (req_last & (last_inflight_ff | rsp_valid_ff));
   assign accept    = req_valid & ~req_stall;
   assign diff      = {req_a_value[DATA_W-1], req_a_value}
                    - {req_b_value[DATA_W-1], req_b_value};
   assign g_in      = gsum_ff + {{(SUM_W-SQ_W){1'b0}}, s2_sq_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_width_ff    <= INV_W'(65536);
         degree_ff       <= DEG_W'(1);
         group_size_ff   <= GS_W'(1);
         weight_scale_ff <= WS_W'(65536);
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_INV_WIDTH:    inv_width_ff    <= csr_wdata[INV_W-1:0];
            CSR_DEGREE:       degree_ff       <= csr_wdata[DEG_W-1:0];
            CSR_GROUP_SIZE:   group_size_ff   <= csr_wdata[GS_W-1:0];
            CSR_WEIGHT_SCALE: weight_scale_ff <= csr_wdata[WS_W-1:0];
            default: ;
         endcase
      end
   end

   // element pipeline: difference, square, group accumulate
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         gsum_ff     <= '0;
      end else begin
         if (accept) pos_ff <= (ge | req_last) ? '0 : pos_p1[GS_W-1:0];
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         if (s2_valid_ff) gsum_ff <= (s2_ge_ff | s2_last_ff) ? '0 : g_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_abs_ff  <= diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
      s1_ge_ff   <= ge;
      s1_last_ff <= req_last;
      s2_sq_ff   <= s1_abs_ff * s1_abs_ff;
      s2_ge_ff   <= s1_ge_ff;
      s2_last_ff <= s1_last_ff;
      s3_g_ff    <= g_in;
      s3_ge_ff   <= s2_ge_ff;
      s3_last_ff <= s2_last_ff;
   end

   assign ctl.group_end = s3_valid_ff & s3_ge_ff;
   assign ctl.clear     = s3_valid_ff & s3_last_ff;
   assign ctl.shift     = issuing_ff;

   for (genvar d = 0; d < MAX_DEGREE; d++) begin : g_cell
      logic [SUM_W-1:0] prev_sum, next_sum;
      logic             prev_act, next_act;
      if (d == 0) begin : g_head
         assign prev_sum = '0;
         assign prev_act = 1'b1;
      end else begin : g_body
         assign prev_sum = c_sum[d-1];
         assign prev_act = c_act[d-1];
      end
      if (d == MAX_DEGREE - 1) begin : g_tail
         assign next_sum = '0;
         assign next_act = 1'b0;
      end else begin : g_link
         assign next_sum = e_sum[d+1];
         assign next_act = e_act[d+1];
      end
      wdrk_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .group_sum   (s3_g_ff),
         .prev_sum    (prev_sum),
         .prev_act    (prev_act),
         .eval_in_sum (next_sum),
         .eval_in_act (next_act),
         .sum         (c_sum[d]),
         .act         (c_act[d]),
         .eval_sum    (e_sum[d]),
         .eval_act    (e_act[d])
      );
   end

   wdrk_exp u_exp (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (issuing_ff & e_act[0]),
      .in_sum       (e_sum[0]),
      .in_factor    (deg_eff - cnt_ff),
      .inv_width    (inv_width_ff),
      .weight_scale (weight_scale_ff),
      .out_valid    (exp_valid),
      .out_contrib  (exp_contrib),
      .busy         (exp_busy)
   );

   assign done        = evaluating_ff & ~issuing_ff & ~exp_busy;
   assign emit_inside = s3_valid_ff & ~s3_ge_ff & s3_last_ff;
   assign emit        = emit_inside | (done & eval_last_ff);
   assign total_sum   = {1'b0, total_ff} + {{(TOTAL_W+1-CONTRIB_W){1'b0}}, exp_contrib};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff          <= 1'b0;
         evaluating_ff    <= 1'b0;
         issuing_ff       <= 1'b0;
         eval_last_ff     <= 1'b0;
         last_inflight_ff <= 1'b0;
         cnt_ff           <= '0;
         total_ff         <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (accept & ge) busy_ff <= 1'b1;
         else if (done)   busy_ff <= 1'b0;

         if (accept & req_last) last_inflight_ff <= 1'b1;
         else if (emit)         last_inflight_ff <= 1'b0;

         if (ctl.group_end) begin
            evaluating_ff <= 1'b1;
            issuing_ff    <= 1'b1;
            eval_last_ff  <= s3_last_ff;
            cnt_ff        <= '0;
         end else begin
            if (done) evaluating_ff <= 1'b0;
            if (issuing_ff) begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == deg_eff - 1'b1) issuing_ff <= 1'b0;
            end
         end

         priority if (emit)  total_ff <= '0;
         else if (exp_valid) total_ff <= total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
         else                total_ff <= total_ff;

         if (emit)            rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_value_ff <= (|total_ff[TOTAL_W-1:OUT_W]) ? '1 : total_ff[OUT_W-1:0];
         rsp_err_ff   <= emit_inside;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kernel_value = rsp_value_ff;
   assign rsp_length_error = rsp_err_ff;

endmodule

@@ rtl/wdrk_checker.sv @@
`include "weighted_degree_rbf_kernel_defines.svh"

module wdrk_checker
   import wdrk_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic signed [DATA_W-1:0] req_a_value,
   input logic signed [DATA_W-1:0] req_b_value,
   input logic                     req_last,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic [OUT_W-1:0]         rsp_kernel_value,
   input logic                     rsp_length_error,
   input logic                     csr_write,
   input logic [CSR_IDX_W-1:0]     csr_index,
   input logic [CSR_W-1:0]         csr_wdata
);

   `WDRK_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid)

   `WDRK_ASSERT_NOW(a_last_needs_free_out, clock, reset,
      req_valid && !req_stall && req_last, !rsp_valid)

   `WDRK_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_kernel_value) && $stable(rsp_length_error))

endmodule

bind weighted_degree_rbf_kernel wdrk_checker u_checker (.*);

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import wdrk_pkg::*;

   typedef struct {
      logic [OUT_W-1:0] kernel_value;
      logic             length_error;
   } kernel_result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic signed [DATA_W-1:0] req_a_value = '0;
   logic signed [DATA_W-1:0] req_b_value = '0;
   logic                     req_last = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [OUT_W-1:0]         rsp_kernel_value;
   logic                     rsp_length_error;
   logic                     csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [CSR_W-1:0]         csr_wdata = '0;

   kernel_result_type expected_kernels[$];
   int  error_count = 0;
   bit  quiet = 1'b0;
   int  hold_cycles = 0;
   int  idle_left = 0;

   // predictor state
   logic [EXP_W-1:0]   exp_lut [0:EXP_TABLE_SIZE];
   logic [INV_W-1:0]   cur_inv_width;
   logic [DEG_W-1:0]   cur_degree;
   logic [GS_W-1:0]    cur_group_size;
   logic [WS_W-1:0]    cur_weight;
   int                 elem_pos;
   logic [SUM_W-1:0]   group_sq;
   logic [SUM_W-1:0]   run_sum [0:7];
   logic [3:0]         run_tag [0:7];
   logic [TOTAL_W-1:0] kernel_acc;

   weighted_degree_rbf_kernel u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_a_value(req_a_value), .req_b_value(req_b_value), .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_kernel_value(rsp_kernel_value), .rsp_length_error(rsp_length_error),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   initial begin
      #5ms;
      $display("== FAIL ==");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   function automatic logic [63:0] exp_of_sum(input logic [SUM_W-1:0] s);
      logic [63:0] inv, thr, y, i, f, hi, lo;
      inv = 64'(cur_inv_width);
      if (inv == 0) return 64'(exp_lut[0]);
      thr = ((64'd1 << 36) + inv - 1) / inv;
      if (s >= thr) return 0;
      y = 64'(s) * inv * 64'(EXP_TABLE_SIZE);
      i = y >> 36;
      if (i >= EXP_TABLE_SIZE) return 0;
      f = (y >> 20) & 64'hFFFF;
      hi = 64'(exp_lut[i]);
      lo = 64'(exp_lut[i + 1]);
      return hi - (((hi - lo) * f) >> 16);
   endfunction

   function automatic void clear_vector_state();
      elem_pos = 0;
      group_sq = '0;
      kernel_acc = '0;
      for (int d = 0; d < 8; d++) begin
         run_sum[d] = '0;
         run_tag[d] = '0;
      end
   endfunction

   function automatic void close_group();
      int deg;
      logic [63:0] c, t;
      deg = int'(cur_degree);
      if (deg == 0) deg = 1;
      if (deg > 8) deg = 8;
      for (int d = 7; d > 0; d--) begin
         run_sum[d] = run_sum[d-1] + group_sq;
         run_tag[d] = (run_tag[d-1] != 0) ? 4'(d + 1) : 4'd0;
      end
      run_sum[0] = group_sq;
      run_tag[0] = 4'd1;
      for (int d = 0; d < deg; d++) begin
         if (run_tag[d] != 0) begin
            c = (64'(cur_weight) * 64'(deg - d) * exp_of_sum(run_sum[d])) >> 16;
            t = 64'(kernel_acc) + c;
            kernel_acc = (t > 64'hFF_FFFF_FFFF) ? 40'hFF_FFFF_FFFF : t[39:0];
         end
      end
      group_sq = '0;
      elem_pos = 0;
   endfunction

   function automatic void predict_pair(input logic signed [DATA_W-1:0] a,
                                        input logic signed [DATA_W-1:0] b,
                                        input logic last);
      logic signed [DIFF_W:0] diff;
      logic [63:0] ad;
      int gs;
      kernel_result_type r;
      diff = a - b;
      ad = 64'((diff < 0) ? -diff : diff);
      group_sq = SUM_W'(64'(group_sq) + ad * ad);
      gs = int'(cur_group_size);
      if (gs == 0) gs = 1;
      if (gs > MAX_GROUP) gs = MAX_GROUP;
      elem_pos++;
      if (elem_pos >= gs) close_group();
      if (last) begin
         r.kernel_value = (kernel_acc > 40'hFFFF_FFFF) ? 32'hFFFF_FFFF : kernel_acc[31:0];
         r.length_error = (elem_pos != 0);
         expected_kernels.push_back(r);
         clear_vector_state();
      end
   endfunction

   task automatic send_beat(input logic signed [DATA_W-1:0] a,
                            input logic signed [DATA_W-1:0] b,
                            input logic last);
      bit taken;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_a_value <= a;
      req_b_value <= b;
      req_last <= last;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      predict_pair(a, b, last);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_kernels.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_W-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_INV_WIDTH:    cur_inv_width = val[INV_W-1:0];
         CSR_DEGREE:       cur_degree = val[DEG_W-1:0];
         CSR_GROUP_SIZE:   cur_group_size = val[GS_W-1:0];
         CSR_WEIGHT_SCALE: cur_weight = val[WS_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_regs(input logic [CSR_W-1:0] inv, input logic [CSR_W-1:0] deg,
                           input logic [CSR_W-1:0] gs, input logic [CSR_W-1:0] ws);
      drain();
      write_reg(CSR_INV_WIDTH, inv);
      write_reg(CSR_DEGREE, deg);
      write_reg(CSR_GROUP_SIZE, gs);
      write_reg(CSR_WEIGHT_SCALE, ws);
      csr_write <= 1'b0;
   endtask

   function automatic logic [DATA_W-1:0] pick_value(input int mode);
      case (mode)
         0: return DATA_W'($urandom);
         1: return 16'($signed($urandom_range(0, 512)) - 256);
         default: return 16'($signed($urandom_range(0, 32)) - 16);
      endcase
   endfunction

   task automatic send_vector(input int len, input int mode);
      logic [DATA_W-1:0] a;
      for (int i = 0; i < len; i++) begin
         a = pick_value(mode);
         if (mode != 0) send_beat(a, a + pick_value(mode), i == len - 1);
         else send_beat(a, pick_value(mode), i == len - 1);
      end
   endtask

   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else if (quiet) rsp_stall <= 1'b0;
      else if (idle_left > 0) begin
         rsp_stall <= 1'b1;
         idle_left <= idle_left - 1;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_stall <= 1'b1;
         idle_left <= int'($urandom_range(0, 3));
      end else rsp_stall <= 1'b0;
   end

   always begin
      bit fire;
      kernel_result_type exp_r;
      @(negedge clock);
      fire = !reset && rsp_valid && !rsp_stall;
      @(posedge clock);
      if (fire) begin
         if (expected_kernels.size() == 0) report_mismatch("unexpected result beat");
         else begin
            exp_r = expected_kernels.pop_front();
            if (rsp_kernel_value !== exp_r.kernel_value)
               report_mismatch($sformatf("kernel_value %h expected %h",
                               rsp_kernel_value, exp_r.kernel_value));
            if (rsp_length_error !== exp_r.length_error)
               report_mismatch($sformatf("length_error %b expected %b",
                               rsp_length_error, exp_r.length_error));
         end
      end
   end

   task automatic test_defaults();
      send_beat(16'sh7FFF, 16'sh8000, 1'b1);
      send_beat(16'sh0000, 16'sh0000, 1'b1);
      send_beat(16'sh8000, 16'sh7FFF, 1'b0);
      send_beat(16'sh0100, 16'sh0000, 1'b1);
      send_beat(16'shFFFF, 16'sh0000, 1'b1);
   endtask

   task automatic test_register_extremes();
      set_regs(24'd0, 24'd8, 24'd4, 24'd65536);
      send_vector(8, 2);
      send_vector(6, 2);
      set_regs(24'hFFFFFF, 24'd0, 24'd0, 24'h1FFFF);
      send_vector(3, 1);
      set_regs(24'd1, 24'd15, 24'd31, 24'd1);
      send_vector(32, 1);
      send_vector(5, 1);
      set_regs(24'd65536, 24'd3, 24'd16, 24'd10923);
      send_vector(48, 2);
   endtask

   task automatic test_saturation();
      set_regs(24'd0, 24'd8, 24'd1, 24'h1FFFF);
      for (int i = 0; i < 950; i++) send_beat(16'sh1234, 16'sh0034, i == 949);
   endtask

   task automatic test_backpressure();
      set_regs(24'd4096, 24'd2, 24'd2, 24'd21845);
      hold_cycles <= 300;
      for (int v = 0; v < 6; v++) send_vector(4, 1);
   endtask

   task automatic test_random(input int n_items);
      int sent, gs, len, mode;
      logic [CSR_W-1:0] inv;
      sent = 0;
      while (sent < n_items) begin
         if (sent > n_items * 4 / 5) quiet = 1'b1;
         gs = int'($urandom_range(1, 16));
         if ($urandom_range(0, 3) == 0) gs = int'($urandom_range(0, 31));
         case ($urandom_range(0, 3))
            0: inv = CSR_W'($urandom_range(0, 24'hFFFFFF));
            1: inv = CSR_W'($urandom_range(1, 4096));
            default: inv = CSR_W'($urandom_range(4096, 262144));
         endcase
         set_regs(inv, CSR_W'($urandom_range(0, 15)), CSR_W'(gs),
                  CSR_W'($urandom_range(0, 17'h1FFFF)));
         if (gs == 0) gs = 1;
         if (gs > 16) gs = 16;
         repeat ($urandom_range(1, 4)) begin
            len = gs * int'($urandom_range(1, 4));
            if ($urandom_range(0, 4) == 0) len = int'($urandom_range(1, 40));
            mode = int'($urandom_range(0, 2));
            send_vector(len, mode);
            sent += len;
         end
      end
   endtask

   initial begin
      for (int k = 0; k <= EXP_TABLE_SIZE; k++)
         exp_lut[k] = EXP_W'(int'($floor(65536.0 * $exp(-16.0 * k / EXP_TABLE_SIZE) + 0.5)));
      cur_inv_width = 24'd65536;
      cur_degree = 4'd1;
      cur_group_size = 5'd1;
      cur_weight = 17'd65536;
      clear_vector_state();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_defaults();
      test_register_extremes();
      test_backpressure();
      test_saturation();
      test_random(560);
      drain();
      if (error_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
